>>> hdl/cgts_pkg.sv
// Shared types, codes and defaults for the coarse grid trilinear sampler.
// Used by every module of the block but cgts_ram; depends on nothing.
package cgts_pkg;

  // Default geometry: cell size in blocks and grid points per axis.
  // The cell size must be a power of two so that the final floor is a shift.
  localparam int STEP_DEF = 4;
  localparam int GRID_DEF = 5;

  // Fixed field widths.
  localparam int POS_W     = 5;
  localparam int SMP_W     = 16;
  localparam int FACT_W    = 6;
  localparam int ACC_W     = 36;
  localparam int CNT_W     = 3;

  // Item kinds.
  localparam logic [2:0] KIND_WR3 = 3'd0;
  localparam logic [2:0] KIND_WR2 = 3'd1;
  localparam logic [2:0] KIND_Q3  = 3'd2;
  localparam logic [2:0] KIND_Q2  = 3'd3;
  localparam logic [2:0] KIND_EXC = 3'd4;

  typedef struct packed {
    logic [2:0]              kind;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic [POS_W-1:0]        pos_z;
    logic signed [SMP_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] density;
    logic                    may_exceed;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_item;
    logic       write;
    logic       prep;
    logic       wgt;
    logic       issue;
    logic [2:0] corner;
    logic       sat;
    logic       out_load;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_busy;
    logic out_stall;
  } dp_stat_t;

endpackage

>>> hdl/coarse_grid_trilinear_sampler_core.sv
// Coarse grid trilinear sampler: one item at a time. A write is done in the write state.
// A query reads one corner per cycle from the single read port of each grid memory,
// eight for a 3D query or an exceed test and four for a 2D query, drains the product
// pipeline and then, but for an exceed test, floors by a shift and saturates.
// The next item is accepted the cycle after its result loads; a stalled result holds it off.
// Reset (synchronous, active low) clears control and sets the threshold to 0; grids undefined.
module coarse_grid_trilinear_sampler_core #(
  parameter int STEP = cgts_pkg::STEP_DEF,
  parameter int GRID = cgts_pkg::GRID_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cgts_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cgts_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic signed [cgts_pkg::SMP_W-1:0] cfg_data
);
  import cgts_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // The threshold register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  cgts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_data.kind),
    .stat     (stat),
    .cmd      (cmd)
  );

  cgts_dp #(.STEP(STEP), .GRID(GRID)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> hdl/cgts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module cgts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 125
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/cgts_ctrl.sv
// Controller of the sampler: sequences writes, corner reads, rounding and output.
// Depends on cgts_pkg for kinds, command and status types.
module cgts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_kind,
  input  cgts_pkg::dp_stat_t stat,
  output cgts_pkg::ctl_cmd_t cmd
);
  import cgts_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_PREP,
    ST_WGT,
    ST_RUN,
    ST_DRAIN,
    ST_SAT,
    ST_DONE
  } state_t;

  state_t           st_r, st_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       last_corner;

  // A 2D query visits four corners, the other queries eight.
  assign last_corner = (kind_r == KIND_Q2) ? 3'd3 : 3'd7;

  // Next state and commands.
  always_comb begin
    st_nxt   = st_r;
    kind_nxt = kind_r;
    cnt_nxt  = cnt_r;
    cmd      = '0;
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          kind_nxt      = in_kind;
          case (in_kind) inside
            KIND_WR3, KIND_WR2:          st_nxt = ST_WRITE;
            KIND_Q3, KIND_Q2, KIND_EXC:  st_nxt = ST_PREP;
            default:                     st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        st_nxt    = ST_IDLE;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        st_nxt   = ST_WGT;
      end
      ST_WGT: begin
        cmd.wgt = 1'b1;
        cnt_nxt = '0;
        st_nxt  = ST_RUN;
      end
      ST_RUN: begin
        cmd.issue  = 1'b1;
        cmd.corner = cnt_r;
        if (cnt_r == last_corner) begin
          st_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          st_nxt = (kind_r == KIND_EXC) ? ST_DONE : ST_SAT;
        end
      end
      ST_SAT: begin
        cmd.sat = 1'b1;
        st_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.out_stall) begin
          cmd.out_load = 1'b1;
          st_nxt       = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (st_r == ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      kind_r <= KIND_WR3;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      kind_r <= kind_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // A write item goes straight to the write cycle.
  a_write_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_kind == KIND_WR3 || in_kind == KIND_WR2))
    |=> st_r == ST_WRITE)
    else $error("write item did not enter the write cycle");

  // An unknown kind is dropped without leaving idle.
  a_bad_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind > KIND_EXC) |=> st_r == ST_IDLE)
    else $error("unknown kind started work");

  // The corner loop only ends by draining the read pipeline.
  a_run_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN) |=> (st_r == ST_RUN || st_r == ST_DRAIN))
    else $error("corner loop left without draining");

endmodule

>>> hdl/cgts_dp.sv
// Datapath of the sampler: grid memories, weights, accumulator, scaling, output register.
// Depends on cgts_pkg and cgts_ram.
module cgts_dp #(
  parameter int STEP = cgts_pkg::STEP_DEF,
  parameter int GRID = cgts_pkg::GRID_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cgts_pkg::ctl_cmd_t                   cmd,
  output cgts_pkg::dp_stat_t                   stat,
  input  cgts_pkg::in_item_t                   in_data,
  input  logic                                 cfg_valid,
  input  logic signed [cgts_pkg::SMP_W-1:0]    cfg_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output cgts_pkg::out_item_t                  out_data
);
  import cgts_pkg::*;

  localparam int N3   = GRID * GRID * GRID;
  localparam int N2   = GRID * GRID;
  localparam int A3_W = $clog2(N3);
  localparam int A2_W = $clog2(N2);
  localparam int D3   = STEP * STEP * STEP;
  localparam int D2   = STEP * STEP;
  localparam int AB_W = 2 * FACT_W;
  localparam int W_W  = 3 * FACT_W;
  localparam int P_W  = SMP_W + W_W;
  // The cell volume is a power of two, so the final floor is an arithmetic shift.
  localparam int SH3  = 3 * $clog2(STEP);
  localparam int SH2  = 2 * $clog2(STEP);
  // Half range times the cell volume: the saturation limits of the weighted sum.
  localparam logic signed [ACC_W-1:0] LIM3 = ACC_W'(32768 * D3);
  localparam logic signed [ACC_W-1:0] LIM2 = ACC_W'(32768 * D2);

  // Cell index of one axis: pos / STEP, clamped to GRID-2.
  function automatic logic [POS_W-1:0] cell_of(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] g;
    g = '0;
    for (int k = 1; k <= GRID - 2; k++) begin
      if (int'(p) >= k * STEP) begin
        g = POS_W'(k);
      end
    end
    return g;
  endfunction

  in_item_t                  item_r;
  logic signed [SMP_W-1:0]   thr_r;
  logic [POS_W-1:0]          gx_r, gy_r, gz_r;
  logic [POS_W-1:0]          gx_nxt, gy_nxt, gz_nxt;
  logic [POS_W-1:0]          fx, fy, fz;
  logic signed [FACT_W-1:0]  fa_r [2];
  logic signed [FACT_W-1:0]  fb_r [2];
  logic signed [FACT_W-1:0]  fc_r [2];
  logic signed [AB_W-1:0]    ab_r [4];
  logic                      is2d;
  logic                      we3, we2;
  logic [A3_W-1:0]           waddr3, raddr3;
  logic [A2_W-1:0]           waddr2, raddr2;
  logic [SMP_W-1:0]          rdata3, rdata2;
  logic signed [SMP_W-1:0]   rdata;
  logic [POS_W-1:0]          cx, cy, cz, cz2;
  logic signed [W_W-1:0]     w_nxt, w_s1_r;
  logic signed [P_W-1:0]     prod_nxt, prod_s2_r;
  logic                      s1_v_r, s2_v_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      flag_r;
  logic signed [ACC_W-1:0]   lim;
  logic signed [ACC_W-1:0]   acc_sh;
  logic                      hi_r, lo_r;
  logic [SMP_W-1:0]          q_r;
  out_item_t                 res;
  out_item_t                 out_data_r;
  logic                      out_valid_r, out_valid_nxt;

  assign is2d = (item_r.kind == KIND_Q2);

  // Item and threshold registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  // Write addresses; out-of-range grid indices disable the write.
  assign waddr3 = A3_W'(int'(item_r.pos_x)
                  + GRID * (int'(item_r.pos_y) + GRID * int'(item_r.pos_z)));
  assign waddr2 = A2_W'(int'(item_r.pos_x) + GRID * int'(item_r.pos_z));
  assign we3 = cmd.write && (item_r.kind == KIND_WR3) && (int'(item_r.pos_x) < GRID)
               && (int'(item_r.pos_y) < GRID) && (int'(item_r.pos_z) < GRID);
  assign we2 = cmd.write && (item_r.kind == KIND_WR2) && (int'(item_r.pos_x) < GRID)
               && (int'(item_r.pos_z) < GRID);

  // Cell and fraction of each axis.
  assign gx_nxt = cell_of(item_r.pos_x);
  assign gy_nxt = cell_of(item_r.pos_y);
  assign gz_nxt = cell_of(item_r.pos_z);
  assign fx = POS_W'(int'(item_r.pos_x) - int'(gx_nxt) * STEP);
  assign fy = POS_W'(int'(item_r.pos_y) - int'(gy_nxt) * STEP);
  assign fz = POS_W'(int'(item_r.pos_z) - int'(gz_nxt) * STEP);

  // Per-axis lerp weights: STEP-f for the low corner, f for the high corner.
  // A 2D query runs over x and z, with a unit third factor.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      gx_r    <= gx_nxt;
      gy_r    <= gy_nxt;
      gz_r    <= gz_nxt;
      fa_r[0] <= FACT_W'(STEP - int'(fx));
      fa_r[1] <= FACT_W'(int'(fx));
      if (is2d) begin
        fb_r[0] <= FACT_W'(STEP - int'(fz));
        fb_r[1] <= FACT_W'(int'(fz));
        fc_r[0] <= FACT_W'(1);
        fc_r[1] <= FACT_W'(1);
      end else begin
        fb_r[0] <= FACT_W'(STEP - int'(fy));
        fb_r[1] <= FACT_W'(int'(fy));
        fc_r[0] <= FACT_W'(STEP - int'(fz));
        fc_r[1] <= FACT_W'(int'(fz));
      end
    end
  end

  // Products of the first two factors, one per corner pair.
  always_ff @(posedge clk) begin
    if (cmd.wgt) begin
      for (int i = 0; i < 4; i++) begin
        ab_r[i] <= fa_r[i % 2] * fb_r[i / 2];
      end
    end
  end

  // Corner coordinates and read addresses.
  assign cx     = gx_r + POS_W'(cmd.corner[0]);
  assign cy     = gy_r + POS_W'(cmd.corner[1]);
  assign cz     = gz_r + POS_W'(cmd.corner[2]);
  assign cz2    = gz_r + POS_W'(cmd.corner[1]);
  assign raddr3 = A3_W'(int'(cx) + GRID * (int'(cy) + GRID * int'(cz)));
  assign raddr2 = A2_W'(int'(cx) + GRID * int'(cz2));

  cgts_ram #(.WIDTH(SMP_W), .DEPTH(N3)) u_ram3 (
    .clk     (clk),
    .wr_en   (we3),
    .wr_addr (waddr3),
    .wr_data (item_r.sample_value),
    .rd_addr (raddr3),
    .rd_data (rdata3)
  );

  cgts_ram #(.WIDTH(SMP_W), .DEPTH(N2)) u_ram2 (
    .clk     (clk),
    .wr_en   (we2),
    .wr_addr (waddr2),
    .wr_data (item_r.sample_value),
    .rd_addr (raddr2),
    .rd_data (rdata2)
  );

  assign rdata = $signed(is2d ? rdata2 : rdata3);

  // Corner weight, registered alongside the memory read.
  assign w_nxt    = ab_r[cmd.corner[1:0]] * fc_r[cmd.corner[2]];
  assign prod_nxt = rdata * w_s1_r;

  always_ff @(posedge clk) begin
    w_s1_r    <= w_nxt;
    prod_s2_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
    end
  end

  // Weighted sum of the corners and the exceed flag.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      acc_r  <= '0;
      flag_r <= 1'b0;
    end else begin
      if (s2_v_r) begin
        acc_r <= acc_r + ACC_W'(prod_s2_r);
      end
      if (s1_v_r && (rdata > thr_r)) begin
        flag_r <= 1'b1;
      end
    end
  end

  // Saturation limits and the sum floored by the cell volume.
  assign lim    = is2d ? LIM2 : LIM3;
  assign acc_sh = is2d ? (acc_r >>> SH2) : (acc_r >>> SH3);

  // Register the floored value and the saturated ends together.
  always_ff @(posedge clk) begin
    if (cmd.sat) begin
      hi_r <= (acc_r >= lim);
      lo_r <= (acc_r < -lim);
      q_r  <= acc_sh[SMP_W-1:0];
    end
  end

  // Result: the exceed flag for an exceed test, else the floored value or a saturated end.
  always_comb begin
    res = '0;
    if (item_r.kind == KIND_EXC) begin
      res.may_exceed = flag_r;
    end else if (hi_r) begin
      res.density = {1'b0, {(SMP_W - 1){1'b1}}};
    end else if (lo_r) begin
      res.density = {1'b1, {(SMP_W - 1){1'b0}}};
    end else begin
      res.density = q_r;
    end
  end

  // Output register.
  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign stat.pipe_busy = s1_v_r | s2_v_r;
  assign stat.out_stall = out_valid_r & ~out_ready;

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_ready))
    else $error("result overwritten while stalled");

  // Scaling starts only after every corner has reached the accumulator.
  a_sat_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sat |-> !(s1_v_r || s2_v_r))
    else $error("scaling ran with corner products in flight");

  // A 2D query reads only the four corners of its square.
  a_2d_corners: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && item_r.kind == KIND_Q2) |-> !cmd.corner[2])
    else $error("2D query issued a 3D corner");

endmodule
